### rtl/bft_pkg.sv
// Shared types, codes and constants for the buoyancy force and torque block.
// Used by bft_ctrl, bft_dp and buoyancy_force_torque; depends on nothing else.
package bft_pkg;

    localparam int SINE_TABLE_DEPTH = 256;
    localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
    localparam int DIV_STEPS        = 30;
    localparam int CNT_W            = $clog2(DIV_STEPS);

    // Clamp for intermediate products, 2^47 - 1.
    localparam logic [63:0] LIM47   = 64'h0000_7FFF_FFFF_FFFF;
    // Twice the half-metre surface threshold, Q16.16.
    localparam logic signed [34:0] SURF_LIMIT = 35'sd65536;

    // Configuration register indexes.
    localparam logic [2:0] REG_MODE     = 3'd0;
    localparam logic [2:0] REG_VOLUME   = 3'd1;
    localparam logic [2:0] REG_DENSITY  = 3'd2;
    localparam logic [2:0] REG_GRAVITY  = 3'd3;
    localparam logic [2:0] REG_HEIGHT   = 3'd4;
    localparam logic [2:0] REG_AREA     = 3'd5;
    localparam logic [2:0] REG_MC_WIDTH = 3'd6;
    localparam logic [2:0] REG_MC_LEN   = 3'd7;

    // Datapath operations.
    localparam logic [4:0] OP_IDLE    = 5'd0;
    localparam logic [4:0] OP_LOAD    = 5'd1;
    localparam logic [4:0] OP_PREP    = 5'd2;
    localparam logic [4:0] OP_DIV     = 5'd3;
    localparam logic [4:0] OP_MUL_VF  = 5'd4;
    localparam logic [4:0] OP_VOL     = 5'd5;
    localparam logic [4:0] OP_MUL_VR  = 5'd6;
    localparam logic [4:0] OP_MASS    = 5'd7;
    localparam logic [4:0] OP_CLEAR   = 5'd8;
    localparam logic [4:0] OP_QLOAD   = 5'd9;
    localparam logic [4:0] OP_QLO     = 5'd10;
    localparam logic [4:0] OP_QHI     = 5'd11;
    localparam logic [4:0] OP_QFIN    = 5'd12;
    localparam logic [4:0] OP_SAVE_F  = 5'd13;
    localparam logic [4:0] OP_SAVE_TR = 5'd14;
    localparam logic [4:0] OP_SAVE_TP = 5'd15;
    localparam logic [4:0] OP_OUT     = 5'd16;

    // Operand pairs of the scaled multiply.
    localparam logic [2:0] QS_SH_WA  = 3'd0;
    localparam logic [2:0] QS_Q_RHO  = 3'd1;
    localparam logic [2:0] QS_Q_G    = 3'd2;
    localparam logic [2:0] QS_MW_SR  = 3'd3;
    localparam logic [2:0] QS_F_Q    = 3'd4;
    localparam logic [2:0] QS_ML_SP  = 3'd5;

    typedef struct packed {
        logic [4:0] op;
        logic [2:0] qsel;
    } t_cmd;

    typedef struct packed {
        logic surface;
        logic partial;
        logic full;
        logic surf_off;
    } t_status;

    typedef logic signed [17:0] t_sine_tab [SINE_TABLE_DEPTH];

    // Quantized sine in Q16 from a seventh order odd polynomial on the quarter wave.
    function automatic t_sine_tab sine_table();
        t_sine_tab         t;
        longint unsigned   a;
        longint unsigned   quad;
        longint unsigned   u;
        longint unsigned   u2;
        longint unsigned   p;
        longint unsigned   s;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            a    = (longint'(k) * 65536) / SINE_TABLE_DEPTH;
            quad = (a >> 14) & 3;
            u    = (a & 64'h3FFF) << 2;
            if (quad[0])
                u = 65536 - u;
            u2 = (u * u) >> 16;
            p  = 5026996;
            p  = 85569306 - ((u2 * p) >> 16);
            p  = 693598669 - ((u2 * p) >> 16);
            p  = 1686629713 - ((u2 * p) >> 16);
            s  = ((u * p) >> 16) >> 14;
            if (s > 65536)
                s = 65536;
            t[k] = (quad >= 2) ? -18'(s) : 18'(s);
        end
        return t;
    endfunction

    localparam t_sine_tab SINE_TAB = sine_table();

    function automatic logic [SINE_IDX_W-1:0] sine_index(logic [15:0] ang);
        logic [16+SINE_IDX_W:0] pr;
        pr = ang * (SINE_IDX_W+1)'(SINE_TABLE_DEPTH);
        return pr[16 +: SINE_IDX_W];
    endfunction

endpackage

### rtl/bft_ctrl.sv
// Sequencer for the buoyancy evaluation: walks the datapath through one item.
// Depends on bft_pkg for command, status and operation codes.
module bft_ctrl
    import bft_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PREP  = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_MULVF = 4'd3;
    localparam logic [3:0] S_VOL   = 4'd4;
    localparam logic [3:0] S_MULVR = 4'd5;
    localparam logic [3:0] S_MASS  = 4'd6;
    localparam logic [3:0] S_CLEAR = 4'd7;
    localparam logic [3:0] S_QLOAD = 4'd8;
    localparam logic [3:0] S_QLO   = 4'd9;
    localparam logic [3:0] S_QHI   = 4'd10;
    localparam logic [3:0] S_QFIN  = 4'd11;
    localparam logic [3:0] S_SAVE  = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    // The surface chain uses steps 0 to 6, the submerged force step 7.
    localparam logic [2:0] STEP_SUB = 3'd7;

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [2:0]       r_step, n_step;
    logic             r_ovalid, n_ovalid;

    logic [2:0] step_qsel;
    logic [4:0] step_save;
    logic       step_last;

    always_comb begin
        step_qsel = QS_Q_G;
        step_save = OP_IDLE;
        step_last = 1'b0;
        unique case (r_step)
            3'd0: step_qsel = QS_SH_WA;
            3'd1: step_qsel = QS_Q_RHO;
            3'd2: begin
                step_qsel = QS_Q_G;
                step_save = OP_SAVE_F;
            end
            3'd3: step_qsel = QS_MW_SR;
            3'd4: begin
                step_qsel = QS_F_Q;
                step_save = OP_SAVE_TR;
            end
            3'd5: step_qsel = QS_ML_SP;
            3'd6: begin
                step_qsel = QS_F_Q;
                step_save = OP_SAVE_TP;
                step_last = 1'b1;
            end
            default: begin
                step_qsel = QS_Q_G;
                step_save = OP_SAVE_F;
                step_last = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_step   = r_step;
        n_ovalid = r_ovalid && !i_out_ready;
        o_cmd.op   = OP_IDLE;
        o_cmd.qsel = step_qsel;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.op = OP_PREP;
                n_cnt    = '0;
                if (i_status.surface) begin
                    n_step  = 3'd0;
                    n_state = i_status.surf_off ? S_CLEAR : S_QLOAD;
                end else begin
                    n_state = i_status.partial ? S_DIV : S_VOL;
                end
            end
            S_DIV: begin
                o_cmd.op = OP_DIV;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1))
                    n_state = S_MULVF;
            end
            S_MULVF: begin
                o_cmd.op = OP_MUL_VF;
                n_state  = S_VOL;
            end
            S_VOL: begin
                o_cmd.op = OP_VOL;
                n_state  = S_MULVR;
            end
            S_MULVR: begin
                o_cmd.op = OP_MUL_VR;
                n_state  = S_MASS;
            end
            S_MASS: begin
                o_cmd.op = OP_MASS;
                n_step   = STEP_SUB;
                n_state  = S_QLOAD;
            end
            S_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                n_state  = S_OUT;
            end
            S_QLOAD: begin
                o_cmd.op = OP_QLOAD;
                n_state  = S_QLO;
            end
            S_QLO: begin
                o_cmd.op = OP_QLO;
                n_state  = S_QHI;
            end
            S_QHI: begin
                o_cmd.op = OP_QHI;
                n_state  = S_QFIN;
            end
            S_QFIN: begin
                o_cmd.op = OP_QFIN;
                if (step_save != OP_IDLE) begin
                    n_state = S_SAVE;
                end else begin
                    n_step  = r_step + 1'b1;
                    n_state = S_QLOAD;
                end
            end
            S_SAVE: begin
                o_cmd.op = step_save;
                if (step_last) begin
                    n_state = S_OUT;
                end else begin
                    n_step  = r_step + 1'b1;
                    n_state = S_QLOAD;
                end
            end
            S_OUT: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.op = OP_OUT;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_step   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_step   <= n_step;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

`ifndef ASSERT_OFF
    // A new result never overwrites one that is still waiting.
    a_out_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_OUT) |-> (!r_ovalid || i_out_ready))
        else $error("result register overwritten");

    // An accepted beat always starts the preparation step.
    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_PREP))
        else $error("accept did not start evaluation");

    // The divider never runs past its number of steps.
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt < CNT_W'(DIV_STEPS)))
        else $error("divider step count overrun");
`endif

endmodule

### rtl/bft_dp.sv
// Datapath: configuration registers, restoring divider, shared 32x32 multiplier,
// saturating scaled multiply and result register. Depends on bft_pkg.
module bft_dp
    import bft_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data,
    input  logic [191:0]  i_in_data,
    input  t_cmd          i_cmd,
    output t_status       o_status,
    output logic [95:0]   o_out_data,
    output logic [1:0]    o_out_user
);

    // Configuration.
    logic [1:0]  r_mode;
    logic [31:0] r_fv, r_rho, r_g, r_h, r_wa, r_mw, r_ml;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 2'd0;
            r_fv   <= 32'd0;
            r_rho  <= 32'd67371008;
            r_g    <= 32'd642908;
            r_h    <= 32'd65536;
            r_wa   <= 32'd65536;
            r_mw   <= 32'd0;
            r_ml   <= 32'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MODE:     r_mode <= i_cfg_data[1:0];
                REG_VOLUME:   r_fv   <= i_cfg_data;
                REG_DENSITY:  r_rho  <= i_cfg_data;
                REG_GRAVITY:  r_g    <= i_cfg_data;
                REG_HEIGHT:   r_h    <= i_cfg_data;
                REG_AREA:     r_wa   <= i_cfg_data;
                REG_MC_WIDTH: r_mw   <= i_cfg_data;
                default:      r_ml   <= i_cfg_data;
            endcase
        end
    end

    // Input beat.
    logic [31:0] r_z, r_ballast, r_ta, r_tb, r_tc;
    logic [15:0] r_roll, r_pitch;

    // Working registers.
    logic        r_flag, r_sat;
    logic [33:0] r_rem, r_den;
    logic [29:0] r_frac;
    logic [31:0] r_vol;
    logic [63:0] r_prod, r_plo;
    logic [50:0] r_q, r_f, r_tr, r_tp;
    logic [50:0] r_ma;
    logic [31:0] r_mb;
    logic        r_neg;
    logic [95:0] r_out_data;
    logic [1:0]  r_out_user;

    // Position terms.
    logic signed [34:0] z2, hs, s, n, sh_half, sh;
    logic               neq;

    always_comb begin
        z2      = {{2{r_z[31]}}, r_z, 1'b0};
        hs      = {3'b000, r_h};
        s       = z2 + hs;
        n       = hs - z2;
        sh_half = (n[34] ? (n + 35'sd1) : n) >>> 1;
        sh      = s[34] ? hs : sh_half;
        neq     = r_mode[1] && (r_vol == r_fv);
    end

    assign o_status.surface  = r_mode[0];
    assign o_status.partial  = !s[34] && (s != 35'sd0) && r_z[31];
    assign o_status.full     = s[34];
    assign o_status.surf_off = s > SURF_LIMIT;

    // Scaled multiply operands.
    logic [50:0]           qa;
    logic [33:0]           qb;
    logic [15:0]           ang;
    logic signed [17:0]    sine;

    always_comb begin
        ang  = (i_cmd.qsel == QS_ML_SP) ? r_pitch : r_roll;
        sine = SINE_TAB[sine_index(ang)];
        qa   = r_q;
        qb   = {2'b00, r_g};
        unique case (i_cmd.qsel)
            QS_SH_WA: begin
                qa = {{16{sh[34]}}, sh};
                qb = {2'b00, r_wa};
            end
            QS_Q_RHO: qb = {2'b00, r_rho};
            QS_MW_SR: begin
                qa = {{19{r_mw[31]}}, r_mw};
                qb = {{16{sine[17]}}, sine};
            end
            QS_F_Q: begin
                qa = r_f;
                qb = r_q[33:0];
            end
            QS_ML_SP: begin
                qa = {{19{r_ml[31]}}, r_ml};
                qb = {{16{sine[17]}}, sine};
            end
            default: qb = {2'b00, r_g};
        endcase
    end

    // Shared multiplier.
    logic [31:0] mul_x, mul_y;
    logic        mul_en;

    always_comb begin
        mul_x  = r_mb;
        mul_y  = r_ma[31:0];
        mul_en = 1'b1;
        unique case (i_cmd.op)
            OP_QLO:    mul_y = r_ma[31:0];
            OP_QHI:    mul_y = {13'd0, r_ma[50:32]};
            OP_MUL_VF: begin
                mul_x = r_fv;
                mul_y = {2'b00, r_frac};
            end
            OP_MUL_VR: begin
                mul_x = r_vol;
                mul_y = r_rho;
            end
            default:   mul_en = 1'b0;
        endcase
    end

    // Combine of the scaled multiply.
    logic [63:0] q_sum;
    logic [63:0] q_mag;
    logic        q_clip;

    always_comb begin
        q_sum  = {r_prod[47:0], 16'd0} + {16'd0, r_plo[63:16]};
        q_clip = (r_prod[63:31] != '0) || (q_sum > LIM47);
        q_mag  = q_clip ? LIM47 : q_sum;
    end

    function automatic logic [31:0] sat32(logic [50:0] v, output logic clip);
        clip = 1'b1;
        if (!v[50] && (v[50:31] != '0))
            return 32'h7FFF_FFFF;
        if (v[50] && (v[50:31] != '1))
            return 32'h8000_0000;
        clip = 1'b0;
        return v[31:0];
    endfunction

    logic [31:0] o_f, o_tr, o_tp;
    logic        c_f, c_tr, c_tp;
    logic [34:0] div_t;
    logic [50:0] mass;

    always_comb begin
        o_f   = sat32(r_f, c_f);
        o_tr  = sat32(r_tr, c_tr);
        o_tp  = sat32(r_tp, c_tp);
        div_t = {r_rem, 1'b0};
        mass  = {3'b000, r_prod[63:16]}
                - (neq ? 51'd0 : {{19{r_ballast[31]}}, r_ballast});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 1'b1;
        end else if (i_cmd.op == OP_VOL) begin
            if (o_status.partial)
                r_flag <= 1'b0;
            else if (o_status.full)
                r_flag <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_en)
            r_prod <= mul_x * mul_y;
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_z       <= i_in_data[31:0];
                r_roll    <= i_in_data[47:32];
                r_pitch   <= i_in_data[63:48];
                r_ballast <= i_in_data[95:64];
                r_ta      <= i_in_data[127:96];
                r_tb      <= i_in_data[159:128];
                r_tc      <= i_in_data[191:160];
                r_sat     <= 1'b0;
            end
            OP_PREP: begin
                r_rem  <= n[33:0];
                r_den  <= {r_h, 1'b0};
                r_frac <= '0;
            end
            OP_DIV: begin
                if (div_t >= {1'b0, r_den}) begin
                    r_rem  <= 34'(div_t - {1'b0, r_den});
                    r_frac <= {r_frac[28:0], 1'b1};
                end else begin
                    r_rem  <= div_t[33:0];
                    r_frac <= {r_frac[28:0], 1'b0};
                end
            end
            OP_VOL: begin
                if (o_status.partial)
                    r_vol <= r_prod[61:30];
                else if (o_status.full)
                    r_vol <= r_fv;
                else
                    r_vol <= 32'd0;
            end
            OP_MASS: begin
                r_q  <= mass;
                r_tr <= neq ? 51'd0 : ({{19{r_ta[31]}}, r_ta} + {{19{r_tb[31]}}, r_tb});
                r_tp <= neq ? 51'd0 : {{19{r_tc[31]}}, r_tc};
            end
            OP_CLEAR: begin
                r_f  <= '0;
                r_tr <= '0;
                r_tp <= '0;
            end
            OP_QLOAD: begin
                r_neg <= qa[50] ^ qb[33];
                r_ma  <= qa[50] ? (51'd0 - qa) : qa;
                r_mb  <= qb[33] ? 32'(34'd0 - qb) : qb[31:0];
            end
            OP_QHI: r_plo <= r_prod;
            OP_QFIN: begin
                r_q <= r_neg ? (51'd0 - q_mag[50:0]) : q_mag[50:0];
                if (q_clip)
                    r_sat <= 1'b1;
            end
            OP_SAVE_F:  r_f  <= r_q;
            OP_SAVE_TR: r_tr <= 51'd0 - r_q;
            OP_SAVE_TP: r_tp <= 51'd0 - r_q;
            OP_OUT: begin
                r_out_data <= {o_tp, o_tr, o_f};
                r_out_user <= {r_sat | c_f | c_tr | c_tp, r_flag};
            end
            default: ;
        endcase
    end

    assign o_out_data = r_out_data;
    assign o_out_user = r_out_user;

endmodule

### rtl/buoyancy_force_torque.sv
// A partly immersed body passes through the fraction divider first; surface mode runs seven
// scaled multiplies on one shared 32x32 multiplier; a surface item above the surface limit
// only clears the outputs.
// One item at a time: the next beat is taken the cycle after the result is registered.
// Synchronous active-low reset restores the register defaults and sets the submerged flag.
// Top level; depends on bft_pkg, bft_ctrl and bft_dp.
module buoyancy_force_torque
    import bft_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // depth_z[31:0], roll_angle[47:32], pitch_angle[63:48], ballast_mass[95:64],
    // roll_torque_a[127:96], roll_torque_b[159:128], pitch_torque[191:160]
    input  logic [191:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // force_up[31:0], torque_roll[63:32], torque_pitch[95:64]
    output logic [95:0]  o_m_axis_tdata,
    // submerged[0], saturated[1]
    output logic [1:0]   o_m_axis_tuser
);

    t_cmd    cmd;
    t_status status;

    bft_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    bft_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (i_s_axis_tdata),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_data (o_m_axis_tdata),
        .o_out_user (o_m_axis_tuser)
    );

endmodule
